// ----- rtl/ltt_pkg.sv -----
package ltt_pkg;

   localparam logic [1:0] MODE_IDLE    = 2'd1;
   localparam logic [1:0] MODE_TRIGGER = 2'd2;
   localparam logic [1:0] MODE_MIC     = 2'd3;

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_ARM  = 1'b1;

   localparam logic KIND_CLICK   = 1'b0;
   localparam logic KIND_MEASURE = 1'b1;

   localparam logic [1:0] REG_MODE      = 2'd0;
   localparam logic [1:0] REG_THRESHOLD = 2'd1;
   localparam logic [1:0] REG_SPACING   = 2'd2;
   localparam logic [1:0] REG_DEBOUNCE  = 2'd3;

   localparam logic [1:0]  MODE_RESET      = MODE_IDLE;
   localparam logic [11:0] THRESHOLD_RESET = 12'd200;
   localparam logic [31:0] SPACING_RESET   = 32'd5000000;
   localparam logic [31:0] DEBOUNCE_RESET  = 32'd200000;

   localparam int SAMPLE_BITS = 12;
   localparam int REG_BITS    = 32;
   localparam int NUMBER_BITS = 16;

   typedef struct packed {
      logic [1:0]             mode;
      logic [SAMPLE_BITS-1:0] threshold;
      logic [REG_BITS-1:0]    spacing;
      logic [REG_BITS-1:0]    debounce;
   } cfg_type;

endpackage

// ----- rtl/latency_trial_timer.sv -----
// Latency trial timer. Each transfer on the req_ channel is one item: a tick
// (one microsecond of the internal timer, optionally carrying a light sample
// and a microphone edge) or an arm command that loads the trial count. The
// block takes one item every clock cycle while req_stall is low; the item's
// result, when it has one, is presented on the rsp_ channel in the following
// cycle from a single output register. req_stall rises only while that
// register holds a result and rsp_stall is high, so a consumer that never
// stalls sees one item per cycle sustained. A click result (kind 0) marks
// each trigger-mode launch; a measurement result (kind 1) reports the trial
// number, the latency in microseconds modulo the timer width, the crossing
// sample and whether the run is finished. Registers sit on the csr_ APB port
// at byte addresses 0 (mode), 4 (light threshold), 8 (launch spacing) and
// 12 (microphone debounce); write them only while the block is idle.
module latency_trial_timer
   import ltt_pkg::*;
#(
   parameter int TIME_BITS  = 32,
   parameter int COUNT_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_opcode,
   input  logic                   req_sample_valid,
   input  logic [SAMPLE_BITS-1:0] req_light_sample,
   input  logic                   req_mic_edge,
   input  logic [15:0]            req_trial_count,

   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_kind,
   output logic [NUMBER_BITS-1:0] rsp_trial_number,
   output logic [31:0]            rsp_latency_us,
   output logic [SAMPLE_BITS-1:0] rsp_light_level,
   output logic                   rsp_run_done,

   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [3:0]             csr_paddr,
   input  logic [REG_BITS-1:0]    csr_pwdata,
   output logic [REG_BITS-1:0]    csr_prdata,
   output logic                   csr_pready
);

   localparam int CMP_BITS = (TIME_BITS > REG_BITS) ? TIME_BITS : REG_BITS;
   localparam int CNT_EXT  = (COUNT_BITS > 16) ? COUNT_BITS : 16;

   cfg_type cfg_ff, cfg_in;

   logic [TIME_BITS-1:0]  time_now_ff, time_now_in;
   logic [TIME_BITS-1:0]  last_launch_ff, last_launch_in;
   logic [TIME_BITS-1:0]  start_time_ff, start_time_in;
   logic [TIME_BITS-1:0]  last_mic_ff, last_mic_in;
   logic                  waiting_ff, waiting_in;
   logic [COUNT_BITS-1:0] trials_left_ff, trials_left_in;
   logic [COUNT_BITS-1:0] trial_index_ff, trial_index_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_kind_ff, rsp_kind_in;
   logic [NUMBER_BITS-1:0] rsp_number_ff, rsp_number_in;
   logic [31:0]            rsp_latency_ff, rsp_latency_in;
   logic [SAMPLE_BITS-1:0] rsp_level_ff, rsp_level_in;
   logic                   rsp_done_ff, rsp_done_in;

   logic                  accept;
   logic                  emit;
   logic                  csr_write;
   logic [1:0]            csr_index;
   logic [TIME_BITS-1:0]  time_inc;
   logic [TIME_BITS-1:0]  spacing_t;
   logic [TIME_BITS-1:0]  launch_diff;
   logic [TIME_BITS-1:0]  mic_diff;
   logic [TIME_BITS-1:0]  light_diff;
   logic [CMP_BITS-1:0]   spacing_ext;
   logic [CMP_BITS-1:0]   light_diff_ext;
   logic [COUNT_BITS-1:0] index_inc;
   logic [COUNT_BITS-1:0] left_dec;
   logic [CNT_EXT-1:0]    count_ext;
   logic [CNT_EXT-1:0]    index_inc_ext;
   logic                  mic_ok;
   logic                  started;
   logic                  crossed;
   logic                  launch;

   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign accept     = req_valid && !req_stall;
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[3:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_trial_number = rsp_number_ff;
   assign rsp_latency_us   = rsp_latency_ff;
   assign rsp_light_level  = rsp_level_ff;
   assign rsp_run_done     = rsp_done_ff;

   always_comb begin
      csr_prdata = '0;
      unique case (csr_index)
         REG_MODE:      csr_prdata = REG_BITS'(cfg_ff.mode);
         REG_THRESHOLD: csr_prdata = REG_BITS'(cfg_ff.threshold);
         REG_SPACING:   csr_prdata = cfg_ff.spacing;
         REG_DEBOUNCE:  csr_prdata = cfg_ff.debounce;
         default:       csr_prdata = '0;
      endcase
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_MODE:      cfg_in.mode      = csr_pwdata[1:0];
            REG_THRESHOLD: cfg_in.threshold = csr_pwdata[SAMPLE_BITS-1:0];
            REG_SPACING:   cfg_in.spacing   = csr_pwdata;
            REG_DEBOUNCE:  cfg_in.debounce  = csr_pwdata;
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      time_inc       = time_now_ff + 1'b1;
      spacing_ext    = CMP_BITS'(cfg_ff.spacing);
      spacing_t      = spacing_ext[TIME_BITS-1:0];
      launch_diff    = time_inc - last_launch_ff;
      mic_diff       = time_inc - last_mic_ff;
      light_diff     = time_inc - start_time_ff;
      light_diff_ext = CMP_BITS'(light_diff);
      index_inc      = trial_index_ff + 1'b1;
      index_inc_ext  = CNT_EXT'(index_inc);
      left_dec       = (trials_left_ff != '0) ? trials_left_ff - 1'b1 : trials_left_ff;
      count_ext      = CNT_EXT'(req_trial_count);

      mic_ok  = (cfg_ff.mode == MODE_MIC) && req_mic_edge
                && (CMP_BITS'(mic_diff) > CMP_BITS'(cfg_ff.debounce));
      started = mic_ok && !waiting_ff && (trials_left_ff != '0);
      crossed = waiting_ff && req_sample_valid && (req_light_sample >= cfg_ff.threshold);
      launch  = !waiting_ff && !started && (cfg_ff.mode == MODE_TRIGGER)
                && (trials_left_ff != '0) && (CMP_BITS'(launch_diff) >= spacing_ext);

      time_now_in    = time_now_ff;
      last_launch_in = last_launch_ff;
      start_time_in  = start_time_ff;
      last_mic_in    = last_mic_ff;
      waiting_in     = waiting_ff;
      trials_left_in = trials_left_ff;
      trial_index_in = trial_index_ff;
      emit           = 1'b0;

      rsp_kind_in    = KIND_MEASURE;
      rsp_number_in  = index_inc_ext[NUMBER_BITS-1:0];
      rsp_latency_in = light_diff_ext[31:0];
      rsp_level_in   = req_light_sample;
      rsp_done_in    = (left_dec == '0);

      if (accept) begin
         if (req_opcode == OP_ARM) begin
            trial_index_in = '0;
            trials_left_in = count_ext[COUNT_BITS-1:0];
            waiting_in     = 1'b0;
            if ((cfg_ff.mode == MODE_TRIGGER) && (count_ext[COUNT_BITS-1:0] != '0)) begin
               last_launch_in = time_now_ff - spacing_t;
            end
         end else begin
            time_now_in = time_inc;
            if (mic_ok) begin
               last_mic_in = time_inc;
            end
            if (started) begin
               waiting_in    = 1'b1;
               start_time_in = time_inc;
            end
            if (crossed) begin
               trial_index_in = index_inc;
               waiting_in     = 1'b0;
               trials_left_in = left_dec;
               emit           = 1'b1;
            end else if (launch) begin
               last_launch_in = time_inc;
               start_time_in  = time_inc;
               waiting_in     = 1'b1;
               emit           = 1'b1;
               rsp_kind_in    = KIND_CLICK;
               rsp_latency_in = '0;
               rsp_level_in   = '0;
               rsp_done_in    = 1'b0;
            end
         end
      end

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode      <= MODE_RESET;
         cfg_ff.threshold <= THRESHOLD_RESET;
         cfg_ff.spacing   <= SPACING_RESET;
         cfg_ff.debounce  <= DEBOUNCE_RESET;
         time_now_ff      <= '0;
         last_launch_ff   <= '0;
         start_time_ff    <= '0;
         last_mic_ff      <= '0;
         waiting_ff       <= 1'b0;
         trials_left_ff   <= '0;
         trial_index_ff   <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         cfg_ff           <= cfg_in;
         time_now_ff      <= time_now_in;
         last_launch_ff   <= last_launch_in;
         start_time_ff    <= start_time_in;
         last_mic_ff      <= last_mic_in;
         waiting_ff       <= waiting_in;
         trials_left_ff   <= trials_left_in;
         trial_index_ff   <= trial_index_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_kind_ff    <= rsp_kind_in;
         rsp_number_ff  <= rsp_number_in;
         rsp_latency_ff <= rsp_latency_in;
         rsp_level_ff   <= rsp_level_in;
         rsp_done_ff    <= rsp_done_in;
      end
   end

endmodule

// ----- tb/sv/tb_latency_trial_timer.sv -----
`timescale 1ns / 1ps

module tb_latency_trial_timer;
   import ltt_pkg::*;

   localparam int LIMIT         = 400000;
   localparam int PHASE_ITEMS   = 160;
   localparam int SETTLE_CYCLES = 4;
   localparam int PHASE_COUNT   = 12;
   localparam int ROW_COUNT     = 23;

   localparam logic [1:0] MODE_UNUSED = 2'd0;

   typedef struct packed {
      logic        op;
      logic        svalid;
      logic [11:0] sample;
      logic        mic;
      logic [15:0] count;
   } stim_t;

   typedef struct packed {
      logic        kind;
      logic [15:0] number;
      logic [31:0] latency;
      logic [11:0] level;
      logic        done;
   } report_t;

   typedef struct packed {
      stim_t   item;
      logic    typed;
      logic    has_rsp;
      report_t rsp;
   } vector_t;

   localparam report_t NO_REPORT  = '0;
   localparam report_t FIRST_CLICK = '{KIND_CLICK, 16'd1, 32'd0, 12'd0, 1'b0};

   localparam cfg_type DIRECTED_SETTING = '{MODE_TRIGGER, 12'd100, 32'd3, 32'd0};

   localparam vector_t DIRECTED_ROWS [ROW_COUNT] = '{
      '{'{OP_TICK, 1'b1, 12'hFFF, 1'b1, 16'hFFFF}, 1'b1, 1'b0, NO_REPORT},
      '{'{OP_ARM,  1'b0, 12'h000, 1'b0, 16'd2},    1'b1, 1'b0, NO_REPORT},
      '{'{OP_TICK, 1'b1, 12'hFFF, 1'b0, 16'd0},    1'b1, 1'b1, FIRST_CLICK},
      '{'{OP_TICK, 1'b1, 12'd99,  1'b0, 16'd0},    1'b1, 1'b0, NO_REPORT},
      '{'{OP_TICK, 1'b0, 12'hFFF, 1'b0, 16'd0},    1'b1, 1'b0, NO_REPORT},
      '{'{OP_TICK, 1'b1, 12'd100, 1'b0, 16'd0},    1'b0, 1'b0, NO_REPORT},
      '{'{OP_TICK, 1'b0, 12'h000, 1'b0, 16'd0},    1'b0, 1'b0, NO_REPORT},
      '{'{OP_TICK, 1'b1, 12'hFFF, 1'b0, 16'd0},    1'b0, 1'b0, NO_REPORT},
      '{'{OP_TICK, 1'b1, 12'hFFF, 1'b0, 16'd0},    1'b1, 1'b0, NO_REPORT},
      '{'{OP_ARM,  1'b0, 12'h000, 1'b0, 16'd0},    1'b1, 1'b0, NO_REPORT},
      '{'{OP_TICK, 1'b1, 12'hFFF, 1'b1, 16'd0},    1'b1, 1'b0, NO_REPORT},
      '{'{OP_ARM,  1'b0, 12'h000, 1'b0, 16'hFFFF}, 1'b1, 1'b0, NO_REPORT},
      '{'{OP_TICK, 1'b1, 12'h000, 1'b1, 16'd0},    1'b1, 1'b1, FIRST_CLICK},
      '{'{OP_TICK, 1'b1, 12'h000, 1'b0, 16'd0},    1'b0, 1'b0, NO_REPORT},
      '{'{OP_ARM,  1'b0, 12'h000, 1'b0, 16'd1},    1'b1, 1'b0, NO_REPORT},
      '{'{OP_TICK, 1'b1, 12'hFFF, 1'b0, 16'd0},    1'b1, 1'b1, FIRST_CLICK},
      '{'{OP_TICK, 1'b1, 12'hFFF, 1'b0, 16'd0},    1'b0, 1'b0, NO_REPORT},
      '{'{OP_ARM,  1'b0, 12'h000, 1'b0, 16'd3},    1'b1, 1'b0, NO_REPORT},
      '{'{OP_TICK, 1'b0, 12'h000, 1'b0, 16'd0},    1'b1, 1'b1, FIRST_CLICK},
      '{'{OP_TICK, 1'b1, 12'hAAA, 1'b1, 16'h5555}, 1'b0, 1'b0, NO_REPORT},
      '{'{OP_TICK, 1'b1, 12'h555, 1'b0, 16'hAAAA}, 1'b0, 1'b0, NO_REPORT},
      '{'{OP_TICK, 1'b0, 12'h000, 1'b0, 16'd0},    1'b0, 1'b0, NO_REPORT},
      '{'{OP_TICK, 1'b0, 12'h000, 1'b0, 16'd0},    1'b0, 1'b0, NO_REPORT}
   };

   localparam cfg_type PHASES [PHASE_COUNT] = '{
      '{MODE_MIC,     12'd2000, 32'd3,        32'd5},
      '{MODE_TRIGGER, 12'd0,    32'd0,        32'd0},
      '{MODE_MIC,     12'd4095, 32'hFFFFFFFF, 32'd0},
      '{MODE_TRIGGER, 12'd1500, 32'hFFFFFFFF, 32'd7},
      '{MODE_UNUSED,  12'd300,  32'd4,        32'd4},
      '{MODE_IDLE,    12'd50,   32'd2,        32'd2},
      '{MODE_MIC,     12'd800,  32'd10,       32'hFFFFFFFF},
      '{MODE_TRIGGER, 12'd2048, 32'd20,       32'd0},
      '{MODE_MIC,     12'd1000, 32'd5,        32'd12},
      '{MODE_TRIGGER, 12'd3000, 32'd6,        32'd3},
      '{MODE_MIC,     12'd100,  32'd1,        32'd1},
      '{MODE_TRIGGER, 12'd500,  32'd2,        32'd9}
   };

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic                   req_opcode = OP_TICK;
   logic                   req_sample_valid = 1'b0;
   logic [SAMPLE_BITS-1:0] req_light_sample = '0;
   logic                   req_mic_edge = 1'b0;
   logic [15:0]            req_trial_count = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic                   rsp_kind;
   logic [NUMBER_BITS-1:0] rsp_trial_number;
   logic [31:0]            rsp_latency_us;
   logic [SAMPLE_BITS-1:0] rsp_light_level;
   logic                   rsp_run_done;
   logic                   csr_psel = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite = 1'b0;
   logic [3:0]             csr_paddr = '0;
   logic [REG_BITS-1:0]    csr_pwdata = '0;
   logic [REG_BITS-1:0]    csr_prdata;
   logic                   csr_pready;

   logic [1:0]  cfg_mode = MODE_RESET;
   logic [11:0] cfg_thresh = THRESHOLD_RESET;
   logic [31:0] cfg_spacing = SPACING_RESET;
   logic [31:0] cfg_debounce = DEBOUNCE_RESET;

   logic [31:0] t_now = '0;
   logic [31:0] t_launch = '0;
   logic [31:0] t_start = '0;
   logic [31:0] t_mic = '0;
   logic        waiting = 1'b0;
   logic [15:0] trials_left = '0;
   logic [15:0] trial_idx = '0;

   report_t reports_due[$];
   int      mismatches = 0;
   int      cycles = 0;
   int      stall_burst = 0;
   logic    idle_on = 1'b1;

   latency_trial_timer u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_sample_valid (req_sample_valid),
      .req_light_sample (req_light_sample),
      .req_mic_edge     (req_mic_edge),
      .req_trial_count  (req_trial_count),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_trial_number (rsp_trial_number),
      .rsp_latency_us   (rsp_latency_us),
      .rsp_light_level  (rsp_light_level),
      .rsp_run_done     (rsp_run_done),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic bit timer_step(input stim_t s, output report_t r);
      bit was_waiting;
      bit started;
      r = '0;
      started = 1'b0;
      if (s.op == OP_ARM) begin
         trial_idx = '0;
         trials_left = s.count;
         waiting = 1'b0;
         if (cfg_mode == MODE_TRIGGER && s.count != 0) t_launch = t_now - cfg_spacing;
         return 1'b0;
      end
      t_now = t_now + 32'd1;
      was_waiting = waiting;
      if (cfg_mode == MODE_MIC && s.mic) begin
         if ((t_now - t_mic) > cfg_debounce) begin
            t_mic = t_now;
            if (!was_waiting && trials_left != 0) begin
               waiting = 1'b1;
               t_start = t_now;
               started = 1'b1;
            end
         end
      end
      if (was_waiting) begin
         if (s.svalid && s.sample >= cfg_thresh) begin
            trial_idx = trial_idx + 16'd1;
            waiting = 1'b0;
            if (trials_left != 0) trials_left = trials_left - 16'd1;
            r.kind = KIND_MEASURE;
            r.number = trial_idx;
            r.latency = t_now - t_start;
            r.level = s.sample;
            r.done = (trials_left == 0);
            return 1'b1;
         end
      end else if (!started && cfg_mode == MODE_TRIGGER && trials_left != 0) begin
         if ((t_now - t_launch) >= cfg_spacing) begin
            t_launch = t_now;
            t_start = t_now;
            waiting = 1'b1;
            r.kind = KIND_CLICK;
            r.number = trial_idx + 16'd1;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic string show(input report_t r);
      return $sformatf("kind %0d trial %0d latency %0d level %0d done %0d",
                       r.kind, r.number, r.latency, r.level, r.done);
   endfunction

   task automatic flag(input string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
   endtask

   task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
      logic [31:0] readback;
      logic [31:0] stored;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      readback = csr_prdata;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
      case (idx)
         REG_MODE: begin
            cfg_mode = value[1:0];
            stored = {30'd0, value[1:0]};
         end
         REG_THRESHOLD: begin
            cfg_thresh = value[11:0];
            stored = {20'd0, value[11:0]};
         end
         REG_SPACING: begin
            cfg_spacing = value;
            stored = value;
         end
         default: begin
            cfg_debounce = value;
            stored = value;
         end
      endcase
      if (readback !== stored)
         flag($sformatf("register %0d reads %h, expected %h", idx, readback, stored));
   endtask

   task automatic load_setting(input cfg_type c);
      write_register(REG_MODE, {30'd0, c.mode});
      write_register(REG_THRESHOLD, {20'd0, c.threshold});
      write_register(REG_SPACING, c.spacing);
      write_register(REG_DEBOUNCE, c.debounce);
   endtask

   task automatic send_item(input stim_t s, input bit typed, input bit typed_has,
                            input report_t typed_rsp);
      int gap;
      bit has;
      report_t r;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 14);
         repeat (gap) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
      end
      req_valid <= 1'b1;
      req_opcode <= s.op;
      req_sample_valid <= s.svalid;
      req_light_sample <= s.sample;
      req_mic_edge <= s.mic;
      req_trial_count <= s.count;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      has = timer_step(s, r);
      if (typed) begin
         has = typed_has;
         r = typed_rsp;
      end
      if (has) reports_due.push_back(r);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (reports_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      forever begin
         @(negedge clock);
         if (stall_burst == 0 && idle_on && $urandom_range(0, 7) == 0)
            stall_burst = $urandom_range(1, 14);
         rsp_stall <= (stall_burst != 0);
         if (stall_burst != 0) stall_burst--;
      end
   end

   always @(posedge clock) begin
      report_t got;
      report_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_kind, rsp_trial_number, rsp_latency_us, rsp_light_level, rsp_run_done};
         if (reports_due.size() == 0) begin
            flag($sformatf("unexpected transfer: %s", show(got)));
         end else begin
            want = reports_due.pop_front();
            if (got.kind !== want.kind || got.number !== want.number ||
                got.latency !== want.latency || got.level !== want.level ||
                got.done !== want.done)
               flag($sformatf("transfer mismatch: expected %s, got %s", show(want), show(got)));
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles == LIMIT) begin
         $display("latency_trial_timer regression: fail");
         $finish;
      end
   end

   initial begin
      stim_t s;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      load_setting(DIRECTED_SETTING);
      foreach (DIRECTED_ROWS[i])
         send_item(DIRECTED_ROWS[i].item, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].has_rsp,
                   DIRECTED_ROWS[i].rsp);
      for (int p = 0; p < PHASE_COUNT; p++) begin
         settle();
         load_setting(PHASES[p]);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 40 == 0) idle_on <= (p != PHASE_COUNT - 1) && ($urandom_range(0, 3) != 0);
            if (trials_left == 0)
               s.op = ($urandom_range(0, 3) == 0) ? OP_ARM : OP_TICK;
            else
               s.op = ($urandom_range(0, 29) == 0) ? OP_ARM : OP_TICK;
            s.svalid = 1'($urandom_range(0, 1));
            s.mic = ($urandom_range(0, 4) == 0);
            if (s.op == OP_ARM) begin
               case ($urandom_range(0, 7))
                  0: s.count = 16'd0;
                  1: s.count = 16'hFFFF;
                  2: s.count = 16'($urandom);
                  default: s.count = 16'($urandom_range(1, 6));
               endcase
            end else begin
               s.count = 16'($urandom);
            end
            case ($urandom_range(0, 3))
               0: s.sample = 12'($urandom);
               1: s.sample = (cfg_thresh > 12'd4087) ? 12'hFFF
                                                     : cfg_thresh + 12'($urandom_range(0, 8));
               2: s.sample = (cfg_thresh < 12'd8) ? 12'h000
                                                  : cfg_thresh - 12'($urandom_range(1, 8));
               default: s.sample = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
            endcase
            send_item(s, 1'b0, 1'b0, NO_REPORT);
         end
      end
      settle();
      if (mismatches == 0 && reports_due.size() == 0)
         $display("latency_trial_timer regression: pass");
      else
         $display("latency_trial_timer regression: fail");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/ltt_pkg.sv
rtl/latency_trial_timer.sv
tb/sv/tb_latency_trial_timer.sv
